@@ hdl/ukit_pkg.sv @@
// ----------------------------------------------------------------------------
// ukit_pkg: shared types and constants of the unsorted keyed item table
// Operation and status codes, default sizes and the control word that the
// sequencer hands to every storage cell.
// ----------------------------------------------------------------------------
package ukit_pkg;

  // Default sizes of the table.
  localparam int unsigned CapacityDef    = 16;
  localparam int unsigned KeyBitsDef     = 16;
  localparam int unsigned PayloadBitsDef = 32;

  // Fixed field widths.
  localparam int unsigned KindBits   = 3;
  localparam int unsigned StatusBits = 2;

  // Operation codes carried in the kind field.
  typedef enum logic [KindBits-1:0] {
    KIND_INSERT  = 3'd0,
    KIND_LOOKUP  = 3'd1,
    KIND_DELETE  = 3'd2,
    KIND_CLEAR   = 3'd3,
    KIND_RESTART = 3'd4,
    KIND_NEXT    = 3'd5
  } kind_e;

  // Status codes of a result word.
  typedef enum logic [StatusBits-1:0] {
    STATUS_OK        = 2'd0,
    STATUS_NOT_FOUND = 2'd1,
    STATUS_FULL      = 2'd2,
    STATUS_END       = 2'd3
  } status_e;

  // Control word broadcast to the row of cells.
  typedef struct packed {
    logic cmp_en;   // register the selection flag this cycle
    logic by_key;   // select on key equality
    logic by_idx;   // select on cell position
    logic ins_en;   // shift the row towards the old end
    logic del_en;   // close the gap from the matched cell onwards
  } ukit_ctl_t;

endpackage

@@ hdl/ukit_in_if.sv @@
// ----------------------------------------------------------------------------
// ukit_in_if: request channel of the item table
// Valid/ready channel that carries one operation word.
// ----------------------------------------------------------------------------
interface ukit_in_if
  import ukit_pkg::*;
#(
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
);
  logic                    valid;
  logic                    ready;
  logic [KindBits-1:0]     kind;
  logic [KEY_BITS-1:0]     key;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, kind, key, payload, input ready);
  modport sink   (input valid, kind, key, payload, output ready);
endinterface

@@ hdl/ukit_out_if.sv @@
// ----------------------------------------------------------------------------
// ukit_out_if: result channel of the item table
// Valid/ready channel that carries one result word.
// ----------------------------------------------------------------------------
interface ukit_out_if
  import ukit_pkg::*;
#(
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef,
  parameter int unsigned CNT_BITS     = $clog2(CapacityDef + 1)
);
  logic                    valid;
  logic                    ready;
  logic [StatusBits-1:0]   status;
  logic                    found;
  logic [KEY_BITS-1:0]     item_key;
  logic [PAYLOAD_BITS-1:0] item_payload;
  logic [CNT_BITS-1:0]     item_count;
  logic                    is_full;

  modport source (output valid, status, found, item_key, item_payload, item_count, is_full,
                  input ready);
  modport sink   (input valid, status, found, item_key, item_payload, item_count, is_full,
                  output ready);
endinterface

@@ hdl/ukit_cell.sv @@
// ----------------------------------------------------------------------------
// ukit_cell: one storage cell of the item table
// Holds one key and payload, compares them with the request and takes the
// contents of a neighbouring cell on insert or delete.
// ----------------------------------------------------------------------------
module ukit_cell
  import ukit_pkg::*;
#(
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef,
  parameter int unsigned CNT_BITS     = $clog2(CapacityDef + 1),
  parameter int unsigned IDX          = 0
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  ukit_ctl_t               ctl_i,
  input  logic [CNT_BITS-1:0]     count_i,
  input  logic [KEY_BITS-1:0]     key_i,
  input  logic [CNT_BITS-1:0]     next_idx_i,
  input  logic                    ge_i,
  input  logic [KEY_BITS-1:0]     prev_key_i,
  input  logic [PAYLOAD_BITS-1:0] prev_payload_i,
  input  logic [KEY_BITS-1:0]     next_key_i,
  input  logic [PAYLOAD_BITS-1:0] next_payload_i,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [PAYLOAD_BITS-1:0] payload_o,
  output logic                    sel_o
);

  localparam logic [CNT_BITS-1:0] IdxC = CNT_BITS'(IDX);

  logic [KEY_BITS-1:0]     key_q;
  logic [PAYLOAD_BITS-1:0] payload_q;
  logic                    sel_q, sel_d;
  logic                    in_use;

  // The cell holds a live item only below the fill count.
  assign in_use = (IdxC < count_i);

  // Selection flag: key match for lookup and delete, position for next item.
  always_comb begin
    sel_d = 1'b0;
    if (ctl_i.by_key) begin
      sel_d = in_use && (key_q == key_i);
    end else if (ctl_i.by_idx) begin
      sel_d = in_use && (IdxC == next_idx_i);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sel_q <= 1'b0;
    end else if (ctl_i.cmp_en) begin
      sel_q <= sel_d;
    end
  end

  // Contents move one cell older on insert, one cell newer on delete.
  always_ff @(posedge clk_i) begin
    if (ctl_i.ins_en) begin
      key_q     <= prev_key_i;
      payload_q <= prev_payload_i;
    end else if (ctl_i.del_en && ge_i) begin
      key_q     <= next_key_i;
      payload_q <= next_payload_i;
    end
  end

  assign key_o     = key_q;
  assign payload_o = payload_q;
  assign sel_o     = sel_q;

endmodule

@@ hdl/ukit_pick.sv @@
// ----------------------------------------------------------------------------
// ukit_pick: newest-match selection over the row of cells
// Isolates the lowest selected cell, marks it and every older cell for a
// delete, and gathers the chosen cell's key and payload.
// ----------------------------------------------------------------------------
module ukit_pick
  import ukit_pkg::*;
#(
  parameter int unsigned CAPACITY     = CapacityDef,
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic [CAPACITY-1:0]     sel_i,
  input  logic [KEY_BITS-1:0]     keys_i     [CAPACITY],
  input  logic [PAYLOAD_BITS-1:0] payloads_i [CAPACITY],
  output logic                    hit_o,
  output logic [CAPACITY-1:0]     ge_o,
  output logic [KEY_BITS-1:0]     key_o,
  output logic [PAYLOAD_BITS-1:0] payload_o
);

  logic [CAPACITY-1:0] neg;
  logic [CAPACITY-1:0] first;

  // Two's complement of the flags isolates the lowest set bit, and together
  // with the flags covers that bit and everything above it.
  assign neg   = ~sel_i + CAPACITY'(1);
  assign first = sel_i & neg;
  assign ge_o  = sel_i | neg;
  assign hit_o = |sel_i;

  // AND-OR gather of the one selected cell.
  always_comb begin
    key_o     = '0;
    payload_o = '0;
    for (int unsigned i = 0; i < CAPACITY; i++) begin
      key_o     = key_o     | (keys_i[i]     & {KEY_BITS{first[i]}});
      payload_o = payload_o | (payloads_i[i] & {PAYLOAD_BITS{first[i]}});
    end
  end

endmodule

@@ hdl/unsorted_keyed_item_table_unit.sv @@
// ----------------------------------------------------------------------------
// unsorted_keyed_item_table_unit: bounded store of keyed items
// Insert at the front, newest-match lookup and delete, clear, and an
// iterator from newest to oldest, held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Usage
//   in_i carries one operation word (kind, key, payload); out_o returns one
//   result word for each accepted operation, in order.
//   Each operation runs through a compare step and an update step: in the
//   compare step every cell compares its key (or its position, for next
//   item) and registers a flag; in the update step the newest flagged cell
//   is picked, the row shifts for insert or delete and the result word is
//   registered. A new word is taken in the cycle the previous result is
//   registered, not before. The pick and gather across the whole row sets
//   the timing of the update step.
//   Reset empties the store and rewinds the iterator; cell contents are not
//   cleared, as cells at or beyond the fill count are never read.
//   While the receiver stalls, the result word holds; one further operation
//   is taken and compared, and then waits until the output register frees.
// ----------------------------------------------------------------------------
module unsorted_keyed_item_table_unit
  import ukit_pkg::*;
#(
  parameter int unsigned CAPACITY     = CapacityDef,
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ukit_in_if.sink     in_i,
  ukit_out_if.source  out_o
);

  localparam int unsigned CntBits = $clog2(CAPACITY + 1);
  localparam int unsigned IdxBits = $clog2(CAPACITY);
  localparam logic [CntBits-1:0] CapC = CntBits'(CAPACITY);

  // Sequencer states.
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StCmp  = 2'd1;
  localparam logic [1:0] StUpd  = 2'd2;

  logic [1:0]              state_q, state_d;
  logic [KindBits-1:0]     op_kind_q;
  logic [KEY_BITS-1:0]     op_key_q;
  logic [PAYLOAD_BITS-1:0] op_payload_q;
  logic [CntBits-1:0]      count_q, count_d;
  logic [IdxBits-1:0]      iter_pos_q, iter_pos_d;
  logic                    iter_started_q, iter_started_d;

  logic                    out_valid_q;
  logic [StatusBits-1:0]   out_status_q, out_status_d;
  logic                    out_found_q, out_found_d;
  logic [KEY_BITS-1:0]     out_key_q, out_key_d;
  logic [PAYLOAD_BITS-1:0] out_payload_q, out_payload_d;
  logic [CntBits-1:0]      out_count_q;

  logic                    out_free, fire, accept, full;
  logic [CntBits-1:0]      next_idx;
  ukit_ctl_t               ctl;

  logic [KEY_BITS-1:0]     cell_key     [CAPACITY];
  logic [PAYLOAD_BITS-1:0] cell_payload [CAPACITY];
  logic [CAPACITY-1:0]     cell_sel;
  logic [CAPACITY-1:0]     ge;
  logic                    hit;
  logic [KEY_BITS-1:0]     pick_key;
  logic [PAYLOAD_BITS-1:0] pick_payload;

  // Handshake: a new word is taken when idle or as the current one finishes.
  assign out_free   = !out_valid_q || out_o.ready;
  assign fire       = (state_q == StUpd) && out_free;
  assign in_i.ready = (state_q == StIdle) || fire;
  assign accept     = in_i.valid && in_i.ready;
  assign full       = (count_q == CapC);
  assign next_idx   = iter_started_q ? (CntBits'(iter_pos_q) + CntBits'(1)) : '0;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    if (accept) begin
      state_d = StCmp;
    end else if (fire) begin
      state_d = StIdle;
    end else if (state_q == StCmp) begin
      state_d = StUpd;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  // Captured operation word.
  always_ff @(posedge clk_i) begin
    if (accept) begin
      op_kind_q    <= in_i.kind;
      op_key_q     <= in_i.key;
      op_payload_q <= in_i.payload;
    end
  end

  // Control word for the row of cells.
  always_comb begin
    ctl.cmp_en = (state_q == StCmp);
    ctl.by_key = (op_kind_q == KIND_LOOKUP) || (op_kind_q == KIND_DELETE);
    ctl.by_idx = (op_kind_q == KIND_NEXT);
    ctl.ins_en = fire && (op_kind_q == KIND_INSERT) && !full;
    ctl.del_en = fire && (op_kind_q == KIND_DELETE) && hit;
  end

  // Row of cells; cell 0 holds the newest item.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_BITS-1:0]     prev_key, next_key;
    logic [PAYLOAD_BITS-1:0] prev_payload, next_payload;

    if (i == 0) begin : g_head
      assign prev_key     = op_key_q;
      assign prev_payload = op_payload_q;
    end else begin : g_body
      assign prev_key     = cell_key[i-1];
      assign prev_payload = cell_payload[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign next_key     = cell_key[i];
      assign next_payload = cell_payload[i];
    end else begin : g_link
      assign next_key     = cell_key[i+1];
      assign next_payload = cell_payload[i+1];
    end

    ukit_cell #(
      .KEY_BITS    (KEY_BITS),
      .PAYLOAD_BITS(PAYLOAD_BITS),
      .CNT_BITS    (CntBits),
      .IDX         (i)
    ) u_cell (
      .clk_i         (clk_i),
      .rst_ni        (rst_ni),
      .ctl_i         (ctl),
      .count_i       (count_q),
      .key_i         (op_key_q),
      .next_idx_i    (next_idx),
      .ge_i          (ge[i]),
      .prev_key_i    (prev_key),
      .prev_payload_i(prev_payload),
      .next_key_i    (next_key),
      .next_payload_i(next_payload),
      .key_o         (cell_key[i]),
      .payload_o     (cell_payload[i]),
      .sel_o         (cell_sel[i])
    );
  end

  ukit_pick #(
    .CAPACITY    (CAPACITY),
    .KEY_BITS    (KEY_BITS),
    .PAYLOAD_BITS(PAYLOAD_BITS)
  ) u_pick (
    .sel_i     (cell_sel),
    .keys_i    (cell_key),
    .payloads_i(cell_payload),
    .hit_o     (hit),
    .ge_o      (ge),
    .key_o     (pick_key),
    .payload_o (pick_payload)
  );

  // Result word and next table state.
  always_comb begin
    out_status_d   = STATUS_OK;
    out_found_d    = 1'b0;
    out_key_d      = op_key_q;
    out_payload_d  = op_payload_q;
    count_d        = count_q;
    iter_pos_d     = iter_pos_q;
    iter_started_d = iter_started_q;
    unique case (op_kind_q)
      KIND_INSERT: begin
        if (full) begin
          out_status_d = STATUS_FULL;
        end else begin
          count_d        = count_q + CntBits'(1);
          iter_pos_d     = '0;
          iter_started_d = 1'b0;
        end
      end
      KIND_LOOKUP: begin
        if (hit) begin
          out_found_d   = 1'b1;
          out_key_d     = pick_key;
          out_payload_d = pick_payload;
        end else begin
          out_status_d = STATUS_NOT_FOUND;
        end
      end
      KIND_DELETE: begin
        if (hit) begin
          out_found_d    = 1'b1;
          out_key_d      = pick_key;
          out_payload_d  = pick_payload;
          count_d        = count_q - CntBits'(1);
          iter_pos_d     = '0;
          iter_started_d = 1'b0;
        end else begin
          out_status_d = STATUS_NOT_FOUND;
        end
      end
      KIND_CLEAR: begin
        count_d        = '0;
        iter_pos_d     = '0;
        iter_started_d = 1'b0;
      end
      KIND_RESTART: begin
        iter_pos_d     = '0;
        iter_started_d = 1'b0;
      end
      KIND_NEXT: begin
        if (hit) begin
          out_key_d      = pick_key;
          out_payload_d  = pick_payload;
          iter_pos_d     = next_idx[IdxBits-1:0];
          iter_started_d = 1'b1;
        end else begin
          out_status_d = STATUS_END;
        end
      end
      default: begin
        // Unused kinds echo the request and change nothing.
      end
    endcase
  end

  // Table state registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q        <= '0;
      iter_pos_q     <= '0;
      iter_started_q <= 1'b0;
    end else if (fire) begin
      count_q        <= count_d;
      iter_pos_q     <= iter_pos_d;
      iter_started_q <= iter_started_d;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (fire) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_status_q  <= out_status_d;
      out_found_q   <= out_found_d;
      out_key_q     <= out_key_d;
      out_payload_q <= out_payload_d;
      out_count_q   <= count_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.found        = out_found_q;
  assign out_o.item_key     = out_key_q;
  assign out_o.item_payload = out_payload_q;
  assign out_o.item_count   = out_count_q;
  assign out_o.is_full      = (out_count_q == CapC);

endmodule

@@ hdl/ukit_checker.sv @@
// ----------------------------------------------------------------------------
// ukit_checker: port-level checks of the item table
// Watches the request and result channels and is bound to the top level.
// ----------------------------------------------------------------------------
module ukit_checker
  import ukit_pkg::*;
#(
  parameter int unsigned CAPACITY     = CapacityDef,
  parameter int unsigned KEY_BITS     = KeyBitsDef,
  parameter int unsigned PAYLOAD_BITS = PayloadBitsDef,
  parameter int unsigned CNT_BITS     = $clog2(CapacityDef + 1)
) (
  input logic                    clk_i,
  input logic                    rst_ni,
  input logic                    in_valid_i,
  input logic                    in_ready_i,
  input logic                    out_valid_i,
  input logic                    out_ready_i,
  input logic [StatusBits-1:0]   status_i,
  input logic                    found_i,
  input logic [KEY_BITS-1:0]     item_key_i,
  input logic [PAYLOAD_BITS-1:0] item_payload_i,
  input logic [CNT_BITS-1:0]     item_count_i,
  input logic                    is_full_i
);

  localparam logic [CNT_BITS-1:0] CapC = CNT_BITS'(CAPACITY);

  // The count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (item_count_i <= CapC))
    else $error("item count above capacity");

  // The full flag agrees with the count.
  a_full_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> (is_full_i == (item_count_i == CapC)))
    else $error("full flag disagrees with item count");

  // A match is always reported with ok status.
  a_found_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && found_i) |-> (status_i == STATUS_OK))
    else $error("found set with an error status");

  // Every word passes through the compare state before the next can be taken.
  a_two_cycle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_i) |=> !in_ready_i)
    else $error("request taken in back-to-back cycles");

  // A stalled result word holds.
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=> (out_valid_i && $stable(status_i) && $stable(found_i)
      && $stable(item_key_i) && $stable(item_payload_i) && $stable(item_count_i)))
    else $error("result word changed while stalled");

endmodule

bind unsorted_keyed_item_table_unit ukit_checker #(
  .CAPACITY    (CAPACITY),
  .KEY_BITS    (KEY_BITS),
  .PAYLOAD_BITS(PAYLOAD_BITS),
  .CNT_BITS    ($clog2(CAPACITY + 1))
) u_ukit_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (in_i.valid),
  .in_ready_i    (in_i.ready),
  .out_valid_i   (out_o.valid),
  .out_ready_i   (out_o.ready),
  .status_i      (out_o.status),
  .found_i       (out_o.found),
  .item_key_i    (out_o.item_key),
  .item_payload_i(out_o.item_payload),
  .item_count_i  (out_o.item_count),
  .is_full_i     (out_o.is_full)
);

@@ verif/tb_unsorted_keyed_item_table_unit.sv @@
// ----------------------------------------------------------------------------
// tb_unsorted_keyed_item_table_unit: self-checking bench for the item table
// Drives operation words through the request channel and checks every result
// word against a cycle-free model of the table, kept in step as words are
// accepted. A short directed table comes first. It is followed by random
// fill, walk, probe, churn and noise sequences, with random idling on both
// channels and one long receiver hold-off.
// ----------------------------------------------------------------------------
module tb_unsorted_keyed_item_table_unit;
  import ukit_pkg::*;

  localparam int unsigned Cap  = CapacityDef;
  localparam int unsigned KeyW = KeyBitsDef;
  localparam int unsigned PayW = PayloadBitsDef;
  localparam int unsigned CntW = $clog2(Cap + 1);

  // Spare operation codes that the table must treat as no-ops.
  localparam logic [KindBits-1:0] KindSpareLo = 3'd6;
  localparam logic [KindBits-1:0] KindSpareHi = 3'd7;

  localparam int ItemTarget    = 1575;
  localparam int CalmTail      = 150;
  localparam int PressureAt    = 500;
  localparam int HoldOffCycles = 120;
  localparam int DrainCycles   = 10;
  localparam int RunLimit      = 400000;
  localparam int MaxErrLines   = 50;

  // One result word as the table reports it.
  typedef struct packed {
    status_e           status;
    logic              found;
    logic [KeyW-1:0]   item_key;
    logic [PayW-1:0]   item_payload;
    logic [CntW-1:0]   item_count;
    logic              is_full;
  } reply_t;

  // One row of the directed table; pinned rows carry a hand-written result.
  typedef struct {
    logic [KindBits-1:0] kind;
    logic [KeyW-1:0]     key;
    logic [PayW-1:0]     payload;
    bit                  pinned;
    reply_t              want;
  } stim_row_t;

  logic clk;
  logic rst_n;

  ukit_in_if  op_bus ();
  ukit_out_if reply_bus ();

  unsorted_keyed_item_table_unit dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (op_bus),
    .out_o  (reply_bus)
  );

  // Mirror of the table contents.
  logic [KeyW-1:0] key_tab [Cap];
  logic [PayW-1:0] pay_tab [Cap];
  int              fill;
  int              iter_at;
  bit              iter_live;

  reply_t    replies_due [$];
  stim_row_t dir_rows [$];

  int errors;
  int words_sent;
  int replies_checked;
  int refused_inserts;
  int delete_hits;
  int reads_past_end;
  int cycle_count;
  int feed_gap_pct;
  bit calm_tail;
  bit hold_off_req;

  // Clock with a period of 12.
  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Print one line per failure, up to a cap, and count them all.
  task automatic report_error(input string msg);
    if (errors < MaxErrLines) begin
      $display("ERROR at %0t: %s", $realtime, msg);
    end
    errors++;
  endtask

  // Newest cell holding the key, or -1.
  function automatic int newest_match(input logic [KeyW-1:0] key);
    int i;
    for (i = 0; i < fill; i++) begin
      if (key_tab[i] == key) return i;
    end
    return -1;
  endfunction

  // Apply one operation word to the mirror and work out its result word.
  task automatic table_apply(input logic [KindBits-1:0] kind, input logic [KeyW-1:0] key,
                             input logic [PayW-1:0] payload, output reply_t r);
    int i;
    int hit;
    int nxt;
    r.status       = STATUS_OK;
    r.found        = 1'b0;
    r.item_key     = key;
    r.item_payload = payload;
    case (kind)
      KIND_INSERT: begin
        if (fill >= Cap) begin
          r.status = STATUS_FULL;
          refused_inserts++;
        end else begin
          for (i = fill; i > 0; i--) begin
            key_tab[i] = key_tab[i-1];
            pay_tab[i] = pay_tab[i-1];
          end
          key_tab[0] = key;
          pay_tab[0] = payload;
          fill++;
          iter_at   = 0;
          iter_live = 1'b0;
        end
      end
      KIND_LOOKUP: begin
        hit = newest_match(key);
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.found        = 1'b1;
          r.item_key     = key_tab[hit];
          r.item_payload = pay_tab[hit];
        end
      end
      KIND_DELETE: begin
        hit = newest_match(key);
        if (hit < 0) begin
          r.status = STATUS_NOT_FOUND;
        end else begin
          r.found        = 1'b1;
          r.item_key     = key_tab[hit];
          r.item_payload = pay_tab[hit];
          for (i = hit; i + 1 < fill; i++) begin
            key_tab[i] = key_tab[i+1];
            pay_tab[i] = pay_tab[i+1];
          end
          fill--;
          iter_at   = 0;
          iter_live = 1'b0;
          delete_hits++;
        end
      end
      KIND_CLEAR: begin
        fill      = 0;
        iter_at   = 0;
        iter_live = 1'b0;
      end
      KIND_RESTART: begin
        iter_at   = 0;
        iter_live = 1'b0;
      end
      KIND_NEXT: begin
        nxt = iter_live ? iter_at + 1 : 0;
        if (nxt >= fill) begin
          r.status = STATUS_END;
          reads_past_end++;
        end else begin
          iter_at        = nxt;
          iter_live      = 1'b1;
          r.item_key     = key_tab[nxt];
          r.item_payload = pay_tab[nxt];
        end
      end
      default: begin
        // Spare codes leave the table alone and echo the word.
      end
    endcase
    r.item_count = CntW'(fill);
    r.is_full    = (fill == Cap);
  endtask

  // Offer one word, after an optional gap, and hold it until it is taken.
  // Called at a rising edge; returns at the edge that accepted the word.
  task automatic offer_word(input logic [KindBits-1:0] kind, input logic [KeyW-1:0] key,
                            input logic [PayW-1:0] payload, input bit pinned,
                            input reply_t want);
    int     n;
    reply_t pred;
    if (!calm_tail && feed_gap_pct > 0 && $urandom_range(1, 100) <= feed_gap_pct) begin
      n = $urandom_range(1, 16);
      op_bus.valid <= 1'b0;
      repeat (n) @(posedge clk);
    end
    op_bus.valid   <= 1'b1;
    op_bus.kind    <= kind;
    op_bus.key     <= key;
    op_bus.payload <= payload;
    @(posedge clk);
    while (op_bus.ready !== 1'b1) @(posedge clk);
    table_apply(kind, key, payload, pred);
    replies_due.push_back(pinned ? want : pred);
    words_sent++;
  endtask

  // Directed rows: one checked by the model, one with a typed-in result.
  task automatic add_row(input logic [KindBits-1:0] kind, input logic [KeyW-1:0] key,
                         input logic [PayW-1:0] payload);
    stim_row_t row;
    row.kind    = kind;
    row.key     = key;
    row.payload = payload;
    row.pinned  = 1'b0;
    row.want    = '0;
    dir_rows.push_back(row);
  endtask

  task automatic add_pin(input logic [KindBits-1:0] kind, input logic [KeyW-1:0] key,
                         input logic [PayW-1:0] payload, input status_e st,
                         input logic fnd, input logic [KeyW-1:0] rkey,
                         input logic [PayW-1:0] rpay, input int cnt);
    stim_row_t row;
    row.kind              = kind;
    row.key               = key;
    row.payload           = payload;
    row.pinned            = 1'b1;
    row.want.status       = st;
    row.want.found        = fnd;
    row.want.item_key     = rkey;
    row.want.item_payload = rpay;
    row.want.item_count   = CntW'(cnt);
    row.want.is_full      = (cnt == Cap);
    dir_rows.push_back(row);
  endtask

  // Mostly keys already stored, else a small pool that collides, else any key.
  function automatic logic [KeyW-1:0] pick_key();
    int sel;
    sel = $urandom_range(0, 9);
    if (sel < 5 && fill > 0) return key_tab[$urandom_range(0, fill - 1)];
    if (sel < 8) return KeyW'($urandom_range(0, 7));
    return KeyW'($urandom_range(0, 65535));
  endfunction

  // Receiver: random stall bursts, quiet stretches and one long hold-off.
  initial begin : drain_side
    int n;
    int mode_left;
    int stall_pct;
    reply_bus.ready = 1'b0;
    mode_left       = 0;
    stall_pct       = 0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (mode_left == 0) begin
        mode_left = $urandom_range(50, 300);
        case ($urandom_range(0, 2))
          0:       stall_pct = 0;
          1:       stall_pct = 10;
          default: stall_pct = 35;
        endcase
      end
      mode_left--;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        reply_bus.ready <= 1'b0;
        repeat (HoldOffCycles) @(posedge clk);
        reply_bus.ready <= 1'b1;
      end else if (!calm_tail && stall_pct > 0 && $urandom_range(1, 100) <= stall_pct) begin
        n = $urandom_range(1, 16);
        reply_bus.ready <= 1'b0;
        repeat (n) @(posedge clk);
        reply_bus.ready <= 1'b1;
      end else begin
        reply_bus.ready <= 1'b1;
      end
    end
  end

  // Compare each accepted result word with the oldest expectation.
  always @(posedge clk) begin : reply_check
    reply_t want;
    if (rst_n === 1'b1 && reply_bus.valid === 1'b1 && reply_bus.ready === 1'b1) begin
      if (replies_due.size() == 0) begin
        report_error("result word with no operation outstanding");
      end else begin
        want = replies_due.pop_front();
        replies_checked++;
        if (reply_bus.status !== want.status)
          report_error($sformatf("status got %0d want %0d", reply_bus.status, want.status));
        if (reply_bus.found !== want.found)
          report_error($sformatf("found got %0b want %0b", reply_bus.found, want.found));
        if (reply_bus.item_key !== want.item_key)
          report_error($sformatf("item_key got %h want %h", reply_bus.item_key,
                                 want.item_key));
        if (reply_bus.item_payload !== want.item_payload)
          report_error($sformatf("item_payload got %h want %h", reply_bus.item_payload,
                                 want.item_payload));
        if (reply_bus.item_count !== want.item_count)
          report_error($sformatf("item_count got %0d want %0d", reply_bus.item_count,
                                 want.item_count));
        if (reply_bus.is_full !== want.is_full)
          report_error($sformatf("is_full got %0b want %0b", reply_bus.is_full,
                                 want.is_full));
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= RunLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding.", cycle_count,
               replies_due.size());
      $display("** unsorted_keyed_item_table_unit: FAILED **");
      $finish;
    end
  end

  // Main sequence: reset, directed table, random sequences, drain, verdict.
  initial begin : main_seq
    int n;
    int dir_count;
    bit pressure_done;
    rst_n           = 1'b0;
    op_bus.valid    = 1'b0;
    op_bus.kind     = KIND_INSERT;
    op_bus.key      = '0;
    op_bus.payload  = '0;
    fill            = 0;
    iter_at         = 0;
    iter_live       = 1'b0;
    errors          = 0;
    words_sent      = 0;
    replies_checked = 0;
    refused_inserts = 0;
    delete_hits     = 0;
    reads_past_end  = 0;
    cycle_count     = 0;
    feed_gap_pct    = 20;
    calm_tail       = 1'b0;
    hold_off_req    = 1'b0;
    pressure_done   = 1'b0;

    // Directed table: empty store, extremes, duplicates, iterator, spare codes.
    add_pin(KIND_NEXT,    16'h0000, 32'h0000_0000, STATUS_END,       1'b0, 16'h0000,
            32'h0000_0000, 0);
    add_pin(KIND_LOOKUP,  16'h0000, 32'hFFFF_FFFF, STATUS_NOT_FOUND, 1'b0, 16'h0000,
            32'hFFFF_FFFF, 0);
    add_pin(KIND_DELETE,  16'hFFFF, 32'h1357_9BDF, STATUS_NOT_FOUND, 1'b0, 16'hFFFF,
            32'h1357_9BDF, 0);
    add_pin(KIND_INSERT,  16'h0000, 32'h0000_0000, STATUS_OK,        1'b0, 16'h0000,
            32'h0000_0000, 1);
    add_pin(KIND_INSERT,  16'hFFFF, 32'hFFFF_FFFF, STATUS_OK,        1'b0, 16'hFFFF,
            32'hFFFF_FFFF, 2);
    add_row(KIND_INSERT,  16'h1234, 32'hA5A5_A5A5);
    add_row(KIND_INSERT,  16'hFFFF, 32'h5A5A_5A5A);
    add_pin(KIND_LOOKUP,  16'hFFFF, 32'h0000_0000, STATUS_OK,        1'b1, 16'hFFFF,
            32'h5A5A_5A5A, 4);
    add_row(KIND_NEXT,    16'h0001, 32'h0000_0001);
    add_row(KIND_NEXT,    16'h0002, 32'h0000_0002);
    add_row(KIND_RESTART, 16'h0003, 32'h0000_0003);
    add_row(KIND_NEXT,    16'h0004, 32'h0000_0004);
    add_row(KIND_NEXT,    16'h0005, 32'h0000_0005);
    add_pin(KIND_DELETE,  16'hFFFF, 32'h0000_0000, STATUS_OK,        1'b1, 16'hFFFF,
            32'h5A5A_5A5A, 3);
    add_row(KIND_NEXT,    16'h0006, 32'h0000_0006);
    add_row(KIND_LOOKUP,  16'hFFFF, 32'h8000_0000);
    add_row(KIND_NEXT,    16'h0007, 32'h0000_0007);
    add_row(KIND_NEXT,    16'h0008, 32'h0000_0008);
    add_row(KIND_NEXT,    16'h0009, 32'h0000_0009);
    add_pin(KindSpareLo,  16'hBEEF, 32'hCAFE_F00D, STATUS_OK,        1'b0, 16'hBEEF,
            32'hCAFE_F00D, 3);
    add_pin(KindSpareHi,  16'h8001, 32'h7FFF_FFFE, STATUS_OK,        1'b0, 16'h8001,
            32'h7FFF_FFFE, 3);
    add_pin(KIND_CLEAR,   16'h4000, 32'h0000_FFFF, STATUS_OK,        1'b0, 16'h4000,
            32'h0000_FFFF, 0);
    add_pin(KIND_NEXT,    16'h00FF, 32'hFFFF_0000, STATUS_END,       1'b0, 16'h00FF,
            32'hFFFF_0000, 0);
    dir_count = dir_rows.size();

    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (dir_rows[i]) begin
      offer_word(dir_rows[i].kind, dir_rows[i].key, dir_rows[i].payload,
                 dir_rows[i].pinned, dir_rows[i].want);
    end

    // Random sequences until the word budget is spent.
    while (words_sent < ItemTarget) begin
      if (words_sent >= ItemTarget - CalmTail) calm_tail = 1'b1;
      case ($urandom_range(0, 2))
        0:       feed_gap_pct = 0;
        1:       feed_gap_pct = 10;
        default: feed_gap_pct = 40;
      endcase
      if (!pressure_done && words_sent >= PressureAt) begin
        // Keep the input busy while the receiver holds off, so the table backs up.
        hold_off_req  = 1'b1;
        pressure_done = 1'b1;
        feed_gap_pct  = 0;
      end
      case ($urandom_range(0, 9))
        0, 1: begin
          // Fill to capacity, then knock on the full store.
          while (fill < Cap) offer_word(KIND_INSERT, pick_key(), $urandom(), 1'b0, '0);
          n = $urandom_range(1, 3);
          repeat (n) offer_word(KIND_INSERT, pick_key(), $urandom(), 1'b0, '0);
        end
        2, 3: begin
          // Walk the list, sometimes from where the iterator already is.
          if ($urandom_range(0, 3) != 0) offer_word(KIND_RESTART, pick_key(), $urandom(),
                                                    1'b0, '0);
          n = fill + $urandom_range(1, 2);
          repeat (n) offer_word(KIND_NEXT, pick_key(), $urandom(), 1'b0, '0);
        end
        4, 5: begin
          // Lookups and deletes, hitting and missing.
          n = $urandom_range(4, 12);
          repeat (n) offer_word($urandom_range(0, 1) ? KIND_LOOKUP : KIND_DELETE,
                                pick_key(), $urandom(), 1'b0, '0);
        end
        6: begin
          // Churn of inserts, deletes and lookups on colliding keys.
          n = $urandom_range(8, 20);
          repeat (n) begin
            case ($urandom_range(0, 2))
              0:       offer_word(KIND_INSERT, pick_key(), $urandom(), 1'b0, '0);
              1:       offer_word(KIND_DELETE, pick_key(), $urandom(), 1'b0, '0);
              default: offer_word(KIND_LOOKUP, pick_key(), $urandom(), 1'b0, '0);
            endcase
          end
        end
        7: begin
          offer_word(KIND_CLEAR, pick_key(), $urandom(), 1'b0, '0);
          n = $urandom_range(0, 4);
          repeat (n) offer_word(KIND_INSERT, pick_key(), $urandom(), 1'b0, '0);
        end
        default: begin
          // Noise: any code, including the spare ones, and any key.
          n = $urandom_range(4, 16);
          repeat (n) begin
            offer_word(($urandom_range(0, 19) == 0) ? KindBits'($urandom_range(6, 7))
                                                    : KindBits'($urandom_range(0, 5)),
                       ($urandom_range(0, 1) == 0) ? KeyW'($urandom_range(0, 65535))
                                                   : pick_key(),
                       $urandom(), 1'b0, '0);
          end
        end
      endcase
    end

    // Drain: wait for every result word, then let the pipeline settle.
    op_bus.valid <= 1'b0;
    while (replies_due.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("Ran %0d operation words (%0d directed) and checked %0d result words.",
             words_sent, dir_count, replies_checked);
    $display("Seen: %0d inserts refused when full, %0d deletes that hit, %0d reads past the end.",
             refused_inserts, delete_hits, reads_past_end);
    if (errors == 0) begin
      $display("** unsorted_keyed_item_table_unit: PASSED **");
    end else begin
      $display("** unsorted_keyed_item_table_unit: FAILED **");
    end
    $finish;
  end

endmodule
